// File: rtl/frc_pkg.sv
// Shared types and constants for the frame receive checker.
// No dependencies; the interfaces and the top level import this package.
package frc_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [BYTE_W-1:0] READ_COMMAND_RESET = 8'h00;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET   = 16'd14;

    // Register index as seen on paddr[2] (byte addresses 0 and 4).
    localparam logic REG_READ_COMMAND = 1'b0;
    localparam logic REG_MAX_LENGTH   = 1'b1;

    typedef enum logic [2:0] {
        POS_IDLE    = 3'd0,
        POS_CMD     = 3'd1,
        POS_LEN_HI  = 3'd2,
        POS_LEN_LO  = 3'd3,
        POS_PAYLOAD = 3'd4,
        POS_SUM_HI  = 3'd5,
        POS_SUM_LO  = 3'd6
    } pos_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_BAD_CMD  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic              frame_done;
        status_t           frame_status;
    } result_t;

endpackage

// File: rtl/frc_if.sv
// Valid/ready channel interfaces for received bytes and for check results.
// Depends on frc_pkg for field widths and the status type.
interface frc_in_if
    import frc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface frc_out_if
    import frc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              frame_done;
    status_t           frame_status;

    modport source (
        output valid, output payload_byte, output payload_valid,
        output frame_done, output frame_status, input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_valid,
        input frame_done, input frame_status, output ready
    );
endinterface

// File: rtl/frame_receive_checker_unit.sv
// Frame receive checker: parses length-prefixed frames and checks their sum.
// An accepted byte that yields a result has it in the output register in the next cycle.
// Throughput: one byte per cycle; the byte is taken whenever the output register
// is empty or being drained in the same cycle.
// Reset: rst_n (async, active low) returns the parser to idle, clears the output
// register and loads read_command = 0, max_length = 14.
module frame_receive_checker_unit
    import frc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    frc_in_if.sink            in_ch,
    frc_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [BYTE_W-1:0] read_command_reg;
    logic [LEN_W-1:0]  max_length_reg;

    pos_t              pos_reg, pos_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;
    logic [LEN_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] len_hi_reg, len_hi_next;
    logic [BYTE_W-1:0] sum_hi_reg, sum_hi_next;

    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;
    logic              res_valid;

    logic              accept;
    logic              cfg_write;
    logic [LEN_W-1:0]  frame_len;
    logic [LEN_W-1:0]  remaining_dec;

    // ---------------- Configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_command_reg <= READ_COMMAND_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_READ_COMMAND)
            begin
                read_command_reg <= pwdata[BYTE_W-1:0];
            end
            else
            begin
                max_length_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_READ_COMMAND)
        begin
            prdata = {{(APB_DW-BYTE_W){1'b0}}, read_command_reg};
        end
        else
        begin
            prdata = {{(APB_DW-LEN_W){1'b0}}, max_length_reg};
        end
    end

    // ---------------- Handshake ----------------
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign frame_len     = {len_hi_reg, in_ch.rx_byte};
    assign remaining_dec = remaining_reg - LEN_W'(1);

    // ---------------- Next state ----------------
    always_comb
    begin
        pos_next       = pos_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        len_hi_next    = len_hi_reg;
        sum_hi_next    = sum_hi_reg;

        if (accept)
        begin
            if (in_ch.frame_start)
            begin
                pos_next       = POS_CMD;
                remaining_next = '0;
                sum_next       = '0;
                len_hi_next    = '0;
                sum_hi_next    = '0;
            end
            else
            begin
                case (pos_reg)
                    POS_CMD:
                    begin
                        pos_next = (in_ch.rx_byte != read_command_reg) ? POS_IDLE : POS_LEN_HI;
                    end
                    POS_LEN_HI:
                    begin
                        len_hi_next = in_ch.rx_byte;
                        pos_next    = POS_LEN_LO;
                    end
                    POS_LEN_LO:
                    begin
                        if (frame_len > max_length_reg)
                        begin
                            pos_next = POS_IDLE;
                        end
                        else
                        begin
                            remaining_next = frame_len;
                            pos_next = (frame_len == '0) ? POS_SUM_HI : POS_PAYLOAD;
                        end
                    end
                    POS_PAYLOAD:
                    begin
                        sum_next       = sum_reg + {{(LEN_W-BYTE_W){1'b0}}, in_ch.rx_byte};
                        remaining_next = remaining_dec;
                        if (remaining_dec == '0)
                        begin
                            pos_next = POS_SUM_HI;
                        end
                    end
                    POS_SUM_HI:
                    begin
                        sum_hi_next = in_ch.rx_byte;
                        pos_next    = POS_SUM_LO;
                    end
                    POS_SUM_LO:
                    begin
                        pos_next = POS_IDLE;
                    end
                    default:
                    begin
                        pos_next = POS_IDLE;
                    end
                endcase
            end
        end
    end

    // ---------------- Result of the current byte ----------------
    always_comb
    begin
        res_valid                 = 1'b0;
        result_next.payload_byte  = '0;
        result_next.payload_valid = 1'b0;
        result_next.frame_done    = 1'b0;
        result_next.frame_status  = ST_OK;

        if (!in_ch.frame_start)
        begin
            case (pos_reg)
                POS_CMD:
                begin
                    if (in_ch.rx_byte != read_command_reg)
                    begin
                        res_valid                = 1'b1;
                        result_next.frame_done   = 1'b1;
                        result_next.frame_status = ST_BAD_CMD;
                    end
                end
                POS_LEN_LO:
                begin
                    if (frame_len > max_length_reg)
                    begin
                        res_valid                = 1'b1;
                        result_next.frame_done   = 1'b1;
                        result_next.frame_status = ST_TOO_LONG;
                    end
                end
                POS_PAYLOAD:
                begin
                    res_valid                 = 1'b1;
                    result_next.payload_byte  = in_ch.rx_byte;
                    result_next.payload_valid = 1'b1;
                end
                POS_SUM_LO:
                begin
                    res_valid              = 1'b1;
                    result_next.frame_done = 1'b1;
                    result_next.frame_status =
                        ({sum_hi_reg, in_ch.rx_byte} == sum_reg) ? ST_OK : ST_BAD_SUM;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ---------------- Registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_IDLE;
            remaining_reg <= '0;
            sum_reg       <= '0;
            len_hi_reg    <= '0;
            sum_hi_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            len_hi_reg    <= len_hi_next;
            sum_hi_reg    <= sum_hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (accept && res_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.payload_byte  = result_reg.payload_byte;
    assign out_ch.payload_valid = result_reg.payload_valid;
    assign out_ch.frame_done    = result_reg.frame_done;
    assign out_ch.frame_status  = result_reg.frame_status;

endmodule

// File: verif/frame_receive_checker_unit_tb.sv
// Self-checking testbench for frame_receive_checker_unit: frames are sent with random gaps
// and stalls, and every payload byte and verdict is checked against an in-bench parser.
// Depends on frc_pkg, the frc_in_if/frc_out_if interfaces and the RTL top level.
module frame_receive_checker_unit_tb
    import frc_pkg::*;
();

    localparam int ITEM_TARGET = 1500;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_WAIT    = 18;
    localparam int SETTLE      = 4;

    localparam logic [APB_AW-1:0] ADDR_READ_CMD = {REG_READ_COMMAND, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_MAX_LEN  = {REG_MAX_LENGTH, 2'b00};

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_CMD,
        FR_TOO_LONG,
        FR_CUT
    } frame_kind_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    frc_in_if  rx_bus ();
    frc_out_if result_bus ();

    frame_receive_checker_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (rx_bus),
        .out_ch  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Parser state and register copies that the expected outputs are computed from.
    pos_t        parse_pos;
    logic [15:0] frame_len;
    logic [15:0] bytes_left;
    logic [15:0] payload_sum;
    logic [7:0]  sum_high;
    logic [7:0]  cfg_read_cmd;
    logic [15:0] cfg_max_len;

    result_t pending_outputs[$];

    int  errors;
    int  bytes_counted;
    int  frame_starts;
    int  cfg_writes;
    int  payload_seen;
    int  verdict_cnt[4];
    int  idle_cycles;
    bit  src_steady;
    bit  sink_steady;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic result_t verdict(input status_t st);
        result_t res;
        res = '0;
        res.frame_done   = 1'b1;
        res.frame_status = st;
        parse_pos = POS_IDLE;
        return res;
    endfunction

    // Advances the parser by one received byte; returns 1 when the byte yields an output.
    function automatic bit parse_rx_byte(input logic [7:0] b, input logic start,
                                         output result_t res);
        res = '0;
        if (start)
        begin
            parse_pos   = POS_CMD;
            frame_len   = '0;
            bytes_left  = '0;
            payload_sum = '0;
            sum_high    = '0;
            return 1'b0;
        end
        case (parse_pos)
            POS_CMD:
            begin
                if (b != cfg_read_cmd)
                begin
                    res = verdict(ST_BAD_CMD);
                    return 1'b1;
                end
                parse_pos = POS_LEN_HI;
            end
            POS_LEN_HI:
            begin
                frame_len = {b, 8'h00};
                parse_pos = POS_LEN_LO;
            end
            POS_LEN_LO:
            begin
                frame_len = {frame_len[15:8], b};
                if (frame_len > cfg_max_len)
                begin
                    res = verdict(ST_TOO_LONG);
                    return 1'b1;
                end
                bytes_left = frame_len;
                if (bytes_left == 16'd0)
                    parse_pos = POS_SUM_HI;
                else
                    parse_pos = POS_PAYLOAD;
            end
            POS_PAYLOAD:
            begin
                payload_sum = payload_sum + 16'(b);
                bytes_left  = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                    parse_pos = POS_SUM_HI;
                res.payload_byte  = b;
                res.payload_valid = 1'b1;
                return 1'b1;
            end
            POS_SUM_HI:
            begin
                sum_high  = b;
                parse_pos = POS_SUM_LO;
            end
            POS_SUM_LO:
            begin
                if ({sum_high, b} == payload_sum)
                    res = verdict(ST_OK);
                else
                    res = verdict(ST_BAD_SUM);
                return 1'b1;
            end
            default:
                parse_pos = POS_IDLE;
        endcase
        return 1'b0;
    endfunction

    // Sends one byte request after a random gap and records what it should produce.
    task automatic send_rx(input logic [7:0] b, input logic start);
        int      gap;
        bit      took;
        result_t res;
        gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 49) == 0)
            src_steady = !src_steady;
        if (gap > 0)
        begin
            rx_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_bus.valid       <= 1'b1;
        rx_bus.rx_byte     <= b;
        rx_bus.frame_start <= start;
        do
        begin
            @(negedge clk);
            took = rx_bus.ready;
            @(posedge clk);
        end
        while (!took);
        bytes_counted++;
        if (start)
            frame_starts++;
        if (parse_rx_byte(b, start, res))
            pending_outputs.push_back(res);
    endtask

    task automatic drain_results();
        rx_bus.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        bit took;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            took = pready;
            @(posedge clk);
        end
        while (!took);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_READ_CMD)
            cfg_read_cmd = data[7:0];
        else
            cfg_max_len = data[15:0];
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] cmd, input logic [15:0] max_len);
        drain_results();
        write_reg(ADDR_READ_CMD, APB_DW'(cmd));
        write_reg(ADDR_MAX_LEN, APB_DW'(max_len));
    endtask

    // Builds one frame of the given kind from the current register settings.
    task automatic send_frame(input frame_kind_t kind, input int len_cap);
        frame_kind_t how;
        logic [15:0] len;
        logic [15:0] sum;
        logic [7:0]  cmd;
        logic [7:0]  b;
        int          cut_at;
        int          k;
        how = kind;
        if (how == FR_TOO_LONG && cfg_max_len == 16'hFFFF)
            how = FR_BAD_SUM;
        cmd = cfg_read_cmd;
        if (how == FR_BAD_CMD)
            cmd = cmd ^ 8'($urandom_range(1, 255));
        if (how == FR_TOO_LONG)
        begin
            if ($urandom_range(0, 1) == 1)
                len = 16'($urandom_range(int'(cfg_max_len) + 1, 65535));
            else
                len = cfg_max_len + 16'd1;
        end
        else
        begin
            len = 16'($urandom_range(0, (int'(cfg_max_len) < len_cap) ?
                                          int'(cfg_max_len) : len_cap));
        end
        send_rx(8'($urandom_range(0, 255)), 1'b1);
        send_rx(cmd, 1'b0);
        if (how != FR_BAD_CMD)
        begin
            send_rx(len[15:8], 1'b0);
            send_rx(len[7:0], 1'b0);
        end
        if (how != FR_BAD_CMD && how != FR_TOO_LONG)
        begin
            // Holding off mid-frame lets the output side empty while the parser waits.
            if ($urandom_range(0, 19) == 0)
                drain_results();
            cut_at = (how == FR_CUT) ? $urandom_range(0, int'(len) + 1) : -1;
            sum = '0;
            for (k = 0; k < int'(len); k++)
            begin
                if (k == cut_at)
                    return;
                b   = 8'($urandom_range(0, 255));
                sum = sum + 16'(b);
                send_rx(b, 1'b0);
            end
            if (how == FR_BAD_SUM)
                sum = sum ^ 16'($urandom_range(1, 65535));
            if (cut_at == int'(len))
                return;
            send_rx(sum[15:8], 1'b0);
            if (cut_at == int'(len) + 1)
                return;
            send_rx(sum[7:0], 1'b0);
        end
        // Trailing bytes, or the ignored rest of a rejected frame.
        repeat ($urandom_range(1, 3))
            send_rx(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_default_registers();
        send_rx(8'h5A, 1'b0);
        send_rx(8'hFF, 1'b1);
        send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0);
        send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0);
        send_rx(8'hAA, 1'b0);
        send_rx(8'h00, 1'b1);
        send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0); send_rx(8'h02, 1'b0);
        send_rx(8'hFF, 1'b0); send_rx(8'h00, 1'b0);
        send_rx(8'h00, 1'b0); send_rx(8'hFE, 1'b0);
        send_rx(8'h7E, 1'b1);
        send_rx(8'h01, 1'b0);
        send_rx(8'h7E, 1'b1);
        send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0); send_rx(8'h0F, 1'b0);
    endtask

    task automatic test_register_extremes();
        set_config(8'hFF, 16'hFFFF);
        // The longest length is accepted, then the frame is abandoned by a new start.
        send_rx(8'h00, 1'b1);
        send_rx(8'hFF, 1'b0); send_rx(8'hFF, 1'b0); send_rx(8'hFF, 1'b0);
        send_rx(8'h01, 1'b0); send_rx(8'h80, 1'b0); send_rx(8'h7F, 1'b0);
        send_rx(8'h33, 1'b1);
        send_rx(8'hFF, 1'b0); send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0);
        send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0);
        send_rx(8'hC3, 1'b0);
        set_config(8'h00, 16'h0000);
        send_rx(8'h80, 1'b1);
        send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0);
        send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0);
        send_rx(8'h01, 1'b1);
        send_rx(8'h00, 1'b0); send_rx(8'h00, 1'b0); send_rx(8'h01, 1'b0);
    endtask

    task automatic test_random_frames();
        frame_kind_t kind;
        logic [15:0] max_len;
        int          pick;
        int          f;
        while (bytes_counted < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                max_len = 16'h0000;
            else if (pick == 1)
                max_len = 16'hFFFF;
            else
                max_len = 16'($urandom_range(1, 40));
            set_config(8'($urandom_range(0, 255)), max_len);
            for (f = 0; f < 8; f++)
            begin
                pick = $urandom_range(0, 9);
                if (f == 7 || pick < 6)
                    kind = FR_GOOD;
                else if (pick == 6)
                    kind = FR_BAD_SUM;
                else if (pick == 7)
                    kind = FR_BAD_CMD;
                else if (pick == 8)
                    kind = FR_TOO_LONG;
                else
                    kind = FR_CUT;
                send_frame(kind, ($urandom_range(0, 19) == 0) ? 300 : 24);
                if (kind != FR_CUT && $urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_rx(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    // Output side: random stall before each result, with stretches of none.
    initial
    begin : result_sink
        int stall;
        bit took;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 39) == 0)
                sink_steady = !sink_steady;
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = result_bus.valid;
                @(posedge clk);
            end
            while (!took);
        end
    end

    task automatic report_field(input string field, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    always @(negedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual byte 0x%0h status %0d",
                         $time, result_bus.payload_byte, result_bus.frame_status);
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result_bus.payload_byte !== want.payload_byte)
                    report_field("payload_byte", want.payload_byte, result_bus.payload_byte);
                if (result_bus.payload_valid !== want.payload_valid)
                    report_field("payload_valid", want.payload_valid, result_bus.payload_valid);
                if (result_bus.frame_done !== want.frame_done)
                    report_field("frame_done", want.frame_done, result_bus.frame_done);
                if (result_bus.frame_status !== want.frame_status)
                    report_field("frame_status", want.frame_status, result_bus.frame_status);
                if (want.payload_valid)
                    payload_seen++;
                if (want.frame_done)
                    verdict_cnt[want.frame_status]++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_bus.valid && rx_bus.ready) || (result_bus.valid && result_bus.ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no request moved for %0d cycles, %0d results outstanding",
                             $time, idle_cycles, pending_outputs.size());
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        rx_bus.valid       <= 1'b0;
        rx_bus.rx_byte     <= '0;
        rx_bus.frame_start <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        parse_pos    = POS_IDLE;
        frame_len    = '0;
        bytes_left   = '0;
        payload_sum  = '0;
        sum_high     = '0;
        cfg_read_cmd = READ_COMMAND_RESET;
        cfg_max_len  = MAX_LENGTH_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_registers();
        test_register_extremes();
        test_random_frames();

        drain_results();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes in %0d frame starts across %0d register writes.",
                 bytes_counted, frame_starts, cfg_writes);
        $write("Checked %0d payload bytes and verdicts %0d ok, ",
               payload_seen, verdict_cnt[ST_OK]);
        $display("%0d bad sum, %0d bad command, %0d too long.",
                 verdict_cnt[ST_BAD_SUM], verdict_cnt[ST_BAD_CMD], verdict_cnt[ST_TOO_LONG]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
